### hw/rtl/sat_pkg.sv
// Shared types and codes for the sensor alarm table.
// Holds the operation and status codes and the packed table entry.
// No dependencies.
`default_nettype none

package sat_pkg;

    typedef enum logic [1:0] {
        KIND_REGISTER = 2'd0,
        KIND_UPDATE   = 2'd1,
        KIND_REMOVE   = 2'd2,
        KIND_SORT     = 2'd3
    } t_kind;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_TOO_FEW   = 3'd4;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] value;
        logic signed [31:0] upper;
        logic signed [31:0] lower;
        logic [1:0]         alarm;
    } t_entry;

endpackage

`default_nettype wire

### hw/rtl/sensor_alarm_table.sv
// Sensor alarm table: ordered table of sensors in one synchronous memory.
// Depends on sat_pkg for codes and the entry layout.
//
// Usage: one request enters on i_in_valid while o_in_stall is low. Each
// request runs to completion before the next is taken. Results leave on
// o_out_valid and are taken when i_out_stall is low; a stalled result holds.
// Register, update and remove give one result; sort gives one result per
// entry (o_last on the final one) or a single status result.
// Without receiver stalls, the time a request takes depends on the number of
// entries in the table and, for register, update and remove, on the position
// of the id; it is set by the single read port of the entry memory, whose
// reads are registered.
// The alarm level is computed combinationally from registered products.
// Reset empties the table (entry count to zero) and drops any result in
// flight; memory contents are left as they are. A stalled receiver stops
// the sequencer at the next result until it is taken.
`default_nettype none

module sensor_alarm_table #(
    parameter int MAX_SENSORS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [1:0]         i_kind,
    input  wire  [15:0]        i_sensor_id,
    input  wire signed [31:0]  i_reading,
    input  wire signed [31:0]  i_upper_limit,
    input  wire signed [31:0]  i_lower_limit,
    input  wire                i_descending,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [2:0]         o_op_status,
    output logic [15:0]        o_entry_id,
    output logic signed [31:0] o_entry_value,
    output logic [1:0]         o_alarm_level,
    output logic               o_last
);

    localparam int AW = $clog2(MAX_SENSORS);
    localparam int CW = $clog2(MAX_SENSORS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_RESP,
        S_REG_WR, S_UPD_MUL, S_UPD_WR,
        S_REM_OUT, S_REM_SHIFT, S_REM_MOVE,
        S_SORT_INIT, S_SORT_LOAD, S_SORT_STEP, S_SORT_TAIL,
        S_EMIT_RD, S_EMIT_OUT
    } t_state;

    t_state             r_state;
    sat_pkg::t_entry    r_mem [MAX_SENSORS];
    sat_pkg::t_entry    r_rdata;
    sat_pkg::t_entry    r_carry;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_k;
    logic [AW-1:0]      r_end;
    sat_pkg::t_kind     r_kind;
    logic [15:0]        r_id;
    logic signed [31:0] r_reading;
    logic signed [31:0] r_upper;
    logic signed [31:0] r_lower;
    logic               r_desc;
    logic [2:0]         r_status;
    logic signed [34:0] r_p5v;
    logic signed [34:0] r_p6h;
    logic signed [34:0] r_p4l;

    logic               can_emit;
    logic               fire;
    logic               k_is_last;
    logic               match;
    logic               swap;
    logic [1:0]         alarm;
    logic signed [34:0] n_p5v;
    logic signed [34:0] n_p6h;
    logic signed [34:0] n_p4l;

    assign o_in_stall = (r_state != S_IDLE);
    assign can_emit   = !o_out_valid || !i_out_stall;
    assign fire       = can_emit && (r_state inside {S_RESP, S_REG_WR, S_UPD_WR,
                                                     S_REM_OUT, S_EMIT_OUT});
    assign k_is_last  = ((CW'(r_k) + CW'(1)) == r_count);
    assign match      = (r_rdata.id == r_id);
    assign swap       = r_desc ? (r_carry.value < r_rdata.value)
                               : (r_carry.value > r_rdata.value);

    assign n_p5v = (35'(r_reading) <<< 2) + 35'(r_reading);
    assign n_p6h = (35'(r_rdata.upper) <<< 2) + (35'(r_rdata.upper) <<< 1);
    assign n_p4l = 35'(r_rdata.lower) <<< 2;

    always_comb begin
        if (r_p5v > r_p6h || r_p5v < r_p4l) begin
            alarm = 2'd2;
        end else if (r_reading > r_upper || r_reading < r_lower) begin
            alarm = 2'd1;
        end else begin
            alarm = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind    <= sat_pkg::t_kind'(i_kind);
                        r_id      <= (sat_pkg::t_kind'(i_kind) == sat_pkg::KIND_SORT)
                                     ? 16'd0 : i_sensor_id;
                        r_reading <= i_reading;
                        r_upper   <= i_upper_limit;
                        r_lower   <= i_lower_limit;
                        r_desc    <= i_descending;
                        r_k       <= '0;
                        if (sat_pkg::t_kind'(i_kind) == sat_pkg::KIND_SORT) begin
                            if (r_count < CW'(2)) begin
                                r_status <= sat_pkg::ST_TOO_FEW;
                                r_state  <= S_RESP;
                            end else begin
                                r_end   <= AW'(r_count - CW'(1));
                                r_state <= S_SORT_INIT;
                            end
                        end else if (sat_pkg::t_kind'(i_kind) == sat_pkg::KIND_REGISTER
                                     && r_count == CW'(MAX_SENSORS)) begin
                            r_status <= sat_pkg::ST_FULL;
                            r_state  <= S_RESP;
                        end else if (r_count == '0) begin
                            if (sat_pkg::t_kind'(i_kind) == sat_pkg::KIND_REGISTER) begin
                                r_state <= S_REG_WR;
                            end else begin
                                r_status <= sat_pkg::ST_NOT_FOUND;
                                r_state  <= S_RESP;
                            end
                        end else begin
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    r_rdata <= r_mem[r_k];
                    r_state <= S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    if (match) begin
                        case (r_kind)
                            sat_pkg::KIND_REGISTER: begin
                                r_status <= sat_pkg::ST_DUPLICATE;
                                r_state  <= S_RESP;
                            end
                            sat_pkg::KIND_UPDATE: r_state <= S_UPD_MUL;
                            default:              r_state <= S_REM_OUT;
                        endcase
                    end else if (k_is_last) begin
                        if (r_kind == sat_pkg::KIND_REGISTER) begin
                            r_state <= S_REG_WR;
                        end else begin
                            r_status <= sat_pkg::ST_NOT_FOUND;
                            r_state  <= S_RESP;
                        end
                    end else begin
                        r_rdata <= r_mem[r_k + AW'(1)];
                        r_k     <= r_k + AW'(1);
                    end
                end
                S_RESP: begin
                    if (can_emit) begin
                        o_op_status   <= r_status;
                        o_entry_id    <= r_id;
                        o_entry_value <= '0;
                        o_alarm_level <= '0;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_REG_WR: begin
                    if (can_emit) begin
                        r_mem[AW'(r_count)] <= '{id: r_id, value: '0, upper: r_upper,
                                                 lower: r_lower, alarm: 2'd0};
                        r_count       <= r_count + CW'(1);
                        o_op_status   <= sat_pkg::ST_OK;
                        o_entry_id    <= r_id;
                        o_entry_value <= '0;
                        o_alarm_level <= '0;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_UPD_MUL: begin
                    r_p5v   <= n_p5v;
                    r_p6h   <= n_p6h;
                    r_p4l   <= n_p4l;
                    r_upper <= r_rdata.upper;
                    r_lower <= r_rdata.lower;
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    if (can_emit) begin
                        r_mem[r_k] <= '{id: r_id, value: r_reading, upper: r_upper,
                                        lower: r_lower, alarm: alarm};
                        o_op_status   <= sat_pkg::ST_OK;
                        o_entry_id    <= r_id;
                        o_entry_value <= r_reading;
                        o_alarm_level <= alarm;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_REM_OUT: begin
                    if (can_emit) begin
                        o_op_status   <= sat_pkg::ST_OK;
                        o_entry_id    <= r_rdata.id;
                        o_entry_value <= r_rdata.value;
                        o_alarm_level <= r_rdata.alarm;
                        o_last        <= 1'b1;
                        r_state       <= S_REM_SHIFT;
                    end
                end
                S_REM_SHIFT: begin
                    if (k_is_last) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_rdata <= r_mem[r_k + AW'(1)];
                        r_state <= S_REM_MOVE;
                    end
                end
                S_REM_MOVE: begin
                    r_mem[r_k] <= r_rdata;
                    r_k        <= r_k + AW'(1);
                    r_state    <= S_REM_SHIFT;
                end
                S_SORT_INIT: begin
                    r_rdata <= r_mem[AW'(0)];
                    r_k     <= '0;
                    r_state <= S_SORT_LOAD;
                end
                S_SORT_LOAD: begin
                    r_carry <= r_rdata;
                    r_rdata <= r_mem[AW'(1)];
                    r_state <= S_SORT_STEP;
                end
                S_SORT_STEP: begin
                    if (swap) begin
                        r_mem[r_k] <= r_rdata;
                    end else begin
                        r_mem[r_k] <= r_carry;
                        r_carry    <= r_rdata;
                    end
                    r_k <= r_k + AW'(1);
                    if (r_k + AW'(1) == r_end) begin
                        r_state <= S_SORT_TAIL;
                    end else begin
                        r_rdata <= r_mem[r_k + AW'(2)];
                    end
                end
                S_SORT_TAIL: begin
                    r_mem[r_end] <= r_carry;
                    r_end        <= r_end - AW'(1);
                    r_k          <= '0;
                    r_state      <= (r_end == AW'(1)) ? S_EMIT_RD : S_SORT_INIT;
                end
                S_EMIT_RD: begin
                    r_rdata <= r_mem[r_k];
                    r_state <= S_EMIT_OUT;
                end
                S_EMIT_OUT: begin
                    if (can_emit) begin
                        o_op_status   <= sat_pkg::ST_OK;
                        o_entry_id    <= r_rdata.id;
                        o_entry_value <= r_rdata.value;
                        o_alarm_level <= r_rdata.alarm;
                        o_last        <= k_is_last;
                        r_k           <= r_k + AW'(1);
                        r_state       <= k_is_last ? S_IDLE : S_EMIT_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
